@@ hdl/cfp_pkg.sv @@
`default_nettype none

package cfp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 16;
  localparam int unsigned BuzDepth = 5;

  localparam logic [ByteW-1:0] START_BYTE = 8'h53;
  localparam logic [ByteW-1:0] POLL_CODE  = 8'h60;
  localparam logic [ByteW-1:0] BUZ_CODE   = 8'h6A;

  localparam logic [CountW-1:0] MIN_FRAME     = 16'd7;
  localparam logic [CountW-1:0] MIN_BUZ_FRAME = 16'd11;
  localparam logic [CountW-1:0] COUNT_MAX     = 16'hFFFF;

  // byte positions inside a frame
  localparam logic [CountW-1:0] POS_ADDR     = 16'd1;
  localparam logic [CountW-1:0] POS_LEN_LO   = 16'd2;
  localparam logic [CountW-1:0] POS_LEN_HI   = 16'd3;
  localparam logic [CountW-1:0] POS_SEQ      = 16'd4;
  localparam logic [CountW-1:0] POS_CMD      = 16'd5;
  localparam logic [CountW-1:0] POS_BUZ_FIRST = 16'd6;
  localparam logic [CountW-1:0] POS_BUZ_LAST  = 16'd10;

  typedef enum logic [0:0] {
    REQ_BYTE = 1'b0,
    REQ_END  = 1'b1
  } req_e;

  typedef enum logic [2:0] {
    ST_POLL      = 3'd0,
    ST_BUZ       = 3'd1,
    ST_SHORT     = 3'd2,
    ST_LEN_BAD   = 3'd3,
    ST_SUM_BAD   = 3'd4,
    ST_UNKNOWN   = 3'd5
  } status_e;

  typedef struct packed {
    logic                           in_frame;
    logic [CountW-1:0]              byte_count;
    logic [ByteW-1:0]               running_sum;
    logic [ByteW-1:0]               addr_byte;
    logic [ByteW-1:0]               length_low;
    logic [ByteW-1:0]               length_high;
    logic [ByteW-1:0]               seq_byte;
    logic [ByteW-1:0]               command_byte;
    logic [BuzDepth-1:0][ByteW-1:0] buzzer_bytes;
  } frame_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [ByteW-1:0] address;
    logic [ByteW-1:0] sequence_res;
    logic [ByteW-1:0] reader_number;
    logic [ByteW-1:0] tone_code;
    logic [ByteW-1:0] on_time;
    logic [ByteW-1:0] off_time;
    logic [ByteW-1:0] repeat_count;
  } result_t;

endpackage

`default_nettype wire

@@ hdl/cfp_if.sv @@
`default_nettype none

interface cfp_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] data_byte;

  modport source (output valid, output req_type, output data_byte, input ready);
  modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

interface cfp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] address;
  logic [7:0] sequence_res;
  logic [7:0] reader_number;
  logic [7:0] tone_code;
  logic [7:0] on_time;
  logic [7:0] off_time;
  logic [7:0] repeat_count;

  modport source (
    output valid, output status, output address, output sequence_res,
    output reader_number, output tone_code, output on_time, output off_time,
    output repeat_count, input ready
  );
  modport sink (
    input valid, input status, input address, input sequence_res,
    input reader_number, input tone_code, input on_time, input off_time,
    input repeat_count, output ready
  );
endinterface

`default_nettype wire

@@ hdl/cfp_frame.sv @@
`default_nettype none

module cfp_frame (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire logic            req_type_i,
  input  wire logic [7:0]      data_byte_i,
  output cfp_pkg::frame_t      frame_o,
  output logic                 close_o
);

  cfp_pkg::frame_t frame_q, frame_d;
  logic            is_start;
  logic [2:0]      buz_idx;

  assign is_start = (data_byte_i == cfp_pkg::START_BYTE);
  assign buz_idx  = 3'(frame_q.byte_count - cfp_pkg::POS_BUZ_FIRST);

  // a frame closes on end of data or on a new start byte
  assign close_o = frame_q.in_frame &&
                   ((req_type_i == cfp_pkg::REQ_END) || is_start);

  always_comb begin
    frame_d = frame_q;
    if (req_type_i == cfp_pkg::REQ_END) begin
      frame_d.in_frame = 1'b0;
    end else if (is_start) begin
      frame_d              = '0;
      frame_d.in_frame     = 1'b1;
      frame_d.byte_count   = 16'd1;
      frame_d.running_sum  = cfp_pkg::START_BYTE;
    end else if (frame_q.in_frame) begin
      unique case (frame_q.byte_count)
        cfp_pkg::POS_ADDR:   frame_d.addr_byte    = data_byte_i;
        cfp_pkg::POS_LEN_LO: frame_d.length_low   = data_byte_i;
        cfp_pkg::POS_LEN_HI: frame_d.length_high  = data_byte_i;
        cfp_pkg::POS_SEQ:    frame_d.seq_byte     = data_byte_i;
        cfp_pkg::POS_CMD:    frame_d.command_byte = data_byte_i;
        default: begin
          if (frame_q.byte_count >= cfp_pkg::POS_BUZ_FIRST &&
              frame_q.byte_count <= cfp_pkg::POS_BUZ_LAST) begin
            frame_d.buzzer_bytes[buz_idx] = data_byte_i;
          end
        end
      endcase
      frame_d.running_sum = frame_q.running_sum + data_byte_i;
      if (frame_q.byte_count != cfp_pkg::COUNT_MAX) begin
        frame_d.byte_count = frame_q.byte_count + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
    end else if (step_i) begin
      frame_q <= frame_d;
    end
  end

  assign frame_o = frame_q;

endmodule

`default_nettype wire

@@ hdl/cfp_verdict.sv @@
`default_nettype none

module cfp_verdict (
  input  wire cfp_pkg::frame_t  frame_i,
  output cfp_pkg::result_t      result_o
);

  logic [15:0]      len_field;
  cfp_pkg::status_e status;

  assign len_field = {frame_i.length_high, frame_i.length_low};

  always_comb begin
    if (frame_i.byte_count < cfp_pkg::MIN_FRAME) begin
      status = cfp_pkg::ST_SHORT;
    end else if (len_field != frame_i.byte_count) begin
      status = cfp_pkg::ST_LEN_BAD;
    end else if (frame_i.running_sum != 8'd0) begin
      status = cfp_pkg::ST_SUM_BAD;
    end else if (frame_i.command_byte == cfp_pkg::POLL_CODE) begin
      status = cfp_pkg::ST_POLL;
    end else if (frame_i.command_byte == cfp_pkg::BUZ_CODE) begin
      status = (frame_i.byte_count < cfp_pkg::MIN_BUZ_FRAME) ?
               cfp_pkg::ST_SHORT : cfp_pkg::ST_BUZ;
    end else begin
      status = cfp_pkg::ST_UNKNOWN;
    end
  end

  always_comb begin
    result_o              = '0;
    result_o.status       = status;
    result_o.address      = frame_i.addr_byte;
    result_o.sequence_res = frame_i.seq_byte;
    if (status == cfp_pkg::ST_BUZ) begin
      result_o.reader_number = frame_i.buzzer_bytes[0];
      result_o.tone_code     = frame_i.buzzer_bytes[1];
      result_o.on_time       = frame_i.buzzer_bytes[2];
      result_o.off_time      = frame_i.buzzer_bytes[3];
      result_o.repeat_count  = frame_i.buzzer_bytes[4];
    end
  end

endmodule

`default_nettype wire

@@ hdl/command_frame_parser_core.sv @@
// channel | dir | payload                                          | handshake
// in_i    | in  | req_type, data_byte                              | valid/ready
// out_o   | out | status, address, sequence_res, buz fields (x5)   | valid/ready
//
// one word per cycle while no closing word waits: input register, then one pass
// of frame update and verdict logic into the result register
// a word that closes no frame moves on even while a result waits
// a closing word waits in the input register until the result register frees
// reset clears the frame state and both valid flags
`default_nettype none

module command_frame_parser_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cfp_in_if.sink     in_i,
  cfp_out_if.source  out_o
);

  logic             in_valid_q;
  logic             req_type_q;
  logic [7:0]       data_byte_q;
  logic             out_valid_q;
  cfp_pkg::result_t result_q;

  cfp_pkg::frame_t  frame;
  cfp_pkg::result_t verdict;
  logic             close;
  logic             step;
  logic             out_free;

  assign out_free = !out_valid_q || out_o.ready;
  assign step     = in_valid_q && (!close || out_free);
  assign in_i.ready = !in_valid_q || step;

  cfp_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .req_type_i  (req_type_q),
    .data_byte_i (data_byte_q),
    .frame_o     (frame),
    .close_o     (close)
  );

  cfp_verdict u_verdict (
    .frame_i  (frame),
    .result_o (verdict)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      req_type_q  <= in_i.req_type;
      data_byte_q <= in_i.data_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && close) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && close) begin
      result_q <= verdict;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = result_q.status;
  assign out_o.address       = result_q.address;
  assign out_o.sequence_res  = result_q.sequence_res;
  assign out_o.reader_number = result_q.reader_number;
  assign out_o.tone_code     = result_q.tone_code;
  assign out_o.on_time       = result_q.on_time;
  assign out_o.off_time      = result_q.off_time;
  assign out_o.repeat_count  = result_q.repeat_count;

endmodule

`default_nettype wire

@@ hdl/cfp_checker.sv @@
`default_nettype none

module cfp_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [2:0] status_i,
  input wire logic [7:0] address_i,
  input wire logic [7:0] reader_number_i,
  input wire logic [7:0] tone_code_i,
  input wire logic [7:0] on_time_i,
  input wire logic [7:0] off_time_i,
  input wire logic [7:0] repeat_count_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) &&
    $stable(address_i))
    else $error("stalled result changed");

  // input side never blocks while no result is pending
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty result register");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> status_i <= cfp_pkg::ST_UNKNOWN)
    else $error("status out of range");

  // buzzer fields only on a buz verdict
  a_buz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != cfp_pkg::ST_BUZ |->
    reader_number_i == 8'd0 && tone_code_i == 8'd0 && on_time_i == 8'd0 &&
    off_time_i == 8'd0 && repeat_count_i == 8'd0)
    else $error("buzzer fields set on non-buz verdict");

  // a fresh result comes from an earlier accepted word
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result appeared without input");

endmodule

bind command_frame_parser_core cfp_checker u_cfp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .status_i        (out_o.status),
  .address_i       (out_o.address),
  .reader_number_i (out_o.reader_number),
  .tone_code_i     (out_o.tone_code),
  .on_time_i       (out_o.on_time),
  .off_time_i      (out_o.off_time),
  .repeat_count_i  (out_o.repeat_count)
);

`default_nettype wire

@@ verif/command_frame_parser_core_tb.sv @@
`timescale 1ns / 1ps

module command_frame_parser_core_tb;
  import cfp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned RAND_WORDS  = 1300;
  localparam int unsigned DRAIN_CYCLES = 12;

  typedef enum int {
    FR_POLL,
    FR_BUZ,
    FR_LEN_BAD,
    FR_SUM_BAD,
    FR_UNKNOWN,
    FR_TRUNC
  } frame_kind_e;

  // predicts one verdict per closed frame and checks the block against it
  class frame_verdict_board;
    result_t           expected_verdicts[$];
    int unsigned       mismatches;
    int unsigned       verdicts_checked;
    int unsigned       status_hits[6];
    logic              in_frame;
    logic [CountW-1:0] byte_count;
    logic [ByteW-1:0]  running_sum;
    logic [ByteW-1:0]  addr_byte;
    logic [ByteW-1:0]  length_low;
    logic [ByteW-1:0]  length_high;
    logic [ByteW-1:0]  seq_byte;
    logic [ByteW-1:0]  command_byte;
    logic [ByteW-1:0]  buzzer_bytes[BuzDepth];

    function new();
      in_frame     = 1'b0;
      byte_count   = '0;
      running_sum  = '0;
      addr_byte    = '0;
      length_low   = '0;
      length_high  = '0;
      seq_byte     = '0;
      command_byte = '0;
      foreach (buzzer_bytes[i]) buzzer_bytes[i] = '0;
      mismatches       = 0;
      verdicts_checked = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    function result_t predict_verdict();
      result_t           r;
      status_e           st;
      logic [CountW-1:0] len_field;
      r = '0;
      len_field = {length_high, length_low};
      if (byte_count < MIN_FRAME) begin
        st = ST_SHORT;
      end else if (len_field != byte_count) begin
        st = ST_LEN_BAD;
      end else if (running_sum != '0) begin
        st = ST_SUM_BAD;
      end else if (command_byte == POLL_CODE) begin
        st = ST_POLL;
      end else if (command_byte == BUZ_CODE) begin
        if (byte_count < MIN_BUZ_FRAME) st = ST_SHORT;
        else st = ST_BUZ;
      end else begin
        st = ST_UNKNOWN;
      end
      r.status       = st;
      r.address      = addr_byte;
      r.sequence_res = seq_byte;
      if (st == ST_BUZ) begin
        r.reader_number = buzzer_bytes[0];
        r.tone_code     = buzzer_bytes[1];
        r.on_time       = buzzer_bytes[2];
        r.off_time      = buzzer_bytes[3];
        r.repeat_count  = buzzer_bytes[4];
      end
      return r;
    endfunction

    function void queue_verdict();
      expected_verdicts = {expected_verdicts, predict_verdict()};
    endfunction

    function void note_word(req_e req, logic [ByteW-1:0] b);
      if (req == REQ_END) begin
        if (in_frame) queue_verdict();
        in_frame = 1'b0;
      end else if (b == START_BYTE) begin
        if (in_frame) queue_verdict();
        in_frame     = 1'b1;
        byte_count   = POS_ADDR;
        running_sum  = START_BYTE;
        addr_byte    = '0;
        length_low   = '0;
        length_high  = '0;
        seq_byte     = '0;
        command_byte = '0;
        foreach (buzzer_bytes[i]) buzzer_bytes[i] = '0;
      end else if (in_frame) begin
        case (byte_count)
          POS_ADDR:   addr_byte    = b;
          POS_LEN_LO: length_low   = b;
          POS_LEN_HI: length_high  = b;
          POS_SEQ:    seq_byte     = b;
          POS_CMD:    command_byte = b;
          default: begin
            if (byte_count >= POS_BUZ_FIRST && byte_count <= POS_BUZ_LAST)
              buzzer_bytes[3'(byte_count - POS_BUZ_FIRST)] = b;
          end
        endcase
        running_sum = running_sum + b;
        if (byte_count != COUNT_MAX) byte_count = byte_count + 1'b1;
      end
    endfunction

    function int unsigned pending();
      return expected_verdicts.size();
    endfunction

    task cmp_field(string name, logic [ByteW-1:0] got, logic [ByteW-1:0] exp);
      if (got !== exp)
        report($sformatf("verdict %0d: %s got %0h exp %0h",
                         verdicts_checked, name, got, exp));
    endtask

    task check_verdict(result_t got);
      result_t exp;
      if (expected_verdicts.size() == 0) begin
        report($sformatf("verdict with nothing pending, status %0h", got.status));
      end else begin
        exp = expected_verdicts.pop_front();
        cmp_field("status", ByteW'(got.status), ByteW'(exp.status));
        cmp_field("address", got.address, exp.address);
        cmp_field("sequence_res", got.sequence_res, exp.sequence_res);
        cmp_field("reader_number", got.reader_number, exp.reader_number);
        cmp_field("tone_code", got.tone_code, exp.tone_code);
        cmp_field("on_time", got.on_time, exp.on_time);
        cmp_field("off_time", got.off_time, exp.off_time);
        cmp_field("repeat_count", got.repeat_count, exp.repeat_count);
        if (exp.status <= ST_UNKNOWN) status_hits[exp.status]++;
        verdicts_checked++;
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  cfp_in_if  in_if ();
  cfp_out_if out_if ();

  command_frame_parser_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  frame_verdict_board sb = new();

  logic [ByteW-1:0] frame_q[$];
  int unsigned      burst_left;
  int unsigned      words_sent;
  int unsigned      cycles;
  result_t          seen_verdict;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.req_type  = REQ_BYTE;
    in_if.data_byte = '0;
    out_if.ready    = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts pending", cycles, sb.pending());
      $display("[command_frame_parser_core] ERROR");
      $finish;
    end
  end

  // receiver stall pattern, cycling through four modes
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      case ((cycles / 97) % 4)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 2) != 0);
        2: out_if.ready <= (cycles % 5 == 0);
        default: out_if.ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      seen_verdict.status        = out_if.status;
      seen_verdict.address       = out_if.address;
      seen_verdict.sequence_res  = out_if.sequence_res;
      seen_verdict.reader_number = out_if.reader_number;
      seen_verdict.tone_code     = out_if.tone_code;
      seen_verdict.on_time       = out_if.on_time;
      seen_verdict.off_time      = out_if.off_time;
      seen_verdict.repeat_count  = out_if.repeat_count;
      sb.check_verdict(seen_verdict);
    end
  end

  task automatic send_word(input req_e req, input logic [ByteW-1:0] b);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      repeat ($urandom_range(0, 4)) begin
        @(negedge clk_i);
        in_if.valid = 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_if.valid     = 1'b1;
    in_if.req_type  = req;
    in_if.data_byte = b;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    sb.note_word(req, b);
    words_sent++;
  endtask

  function automatic logic [ByteW-1:0] body_byte();
    logic [ByteW-1:0] b;
    b = ByteW'($urandom_range(0, 254));
    if (b >= START_BYTE) b = b + 1'b1;
    return b;
  endfunction

  task automatic add_byte(input logic [ByteW-1:0] b);
    frame_q = {frame_q, b};
  endtask

  task automatic send_queue();
    foreach (frame_q[i]) send_word(REQ_BYTE, frame_q[i]);
  endtask

  // appends the byte that brings the frame sum to zero
  task automatic close_sum();
    logic [ByteW-1:0] s;
    s = '0;
    foreach (frame_q[i]) s = s + frame_q[i];
    add_byte(ByteW'(-s));
  endtask

  task automatic build_frame(input frame_kind_e kind);
    int unsigned       n;
    logic [CountW-1:0] len_field;
    logic [ByteW-1:0]  offset;
    logic [ByteW-1:0]  s;
    logic [ByteW-1:0]  last;
    case (kind)
      FR_BUZ:   n = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 10) : $urandom_range(11, 18);
      FR_TRUNC: n = $urandom_range(1, 6);
      default:  n = $urandom_range(7, 16);
    endcase
    frame_q = {};
    add_byte(START_BYTE);
    for (int i = 1; i < n - 1; i++) add_byte(body_byte());
    if (kind == FR_TRUNC) begin
      if (n > 1) add_byte(body_byte());
      return;
    end
    len_field = CountW'(n);
    if (kind == FR_LEN_BAD) begin
      if ($urandom_range(0, 1) == 0) len_field = CountW'($urandom);
      else len_field = ($urandom_range(0, 1) == 0) ? len_field + 1'b1 : len_field - 1'b1;
      if (len_field == CountW'(n)) len_field = len_field + 1'b1;
      if (len_field[7:0] == START_BYTE || len_field[15:8] == START_BYTE)
        len_field = len_field ^ 16'h0101;
    end
    frame_q[POS_LEN_LO] = len_field[7:0];
    frame_q[POS_LEN_HI] = len_field[15:8];
    case (kind)
      FR_POLL: frame_q[POS_CMD] = POLL_CODE;
      FR_BUZ:  frame_q[POS_CMD] = BUZ_CODE;
      FR_UNKNOWN: begin
        do frame_q[POS_CMD] = body_byte();
        while (frame_q[POS_CMD] == POLL_CODE || frame_q[POS_CMD] == BUZ_CODE);
      end
      default: begin
        case ($urandom_range(0, 2))
          0: frame_q[POS_CMD] = POLL_CODE;
          1: frame_q[POS_CMD] = BUZ_CODE;
          default: frame_q[POS_CMD] = body_byte();
        endcase
      end
    endcase
    offset = (kind == FR_SUM_BAD) ? ByteW'($urandom_range(1, 255)) : '0;
    forever begin
      s = '0;
      foreach (frame_q[i]) s = s + frame_q[i];
      last = offset - s;
      if (last != START_BYTE) break;
      frame_q[POS_SEQ] = frame_q[POS_SEQ] + 1'b1;
      if (frame_q[POS_SEQ] == START_BYTE) frame_q[POS_SEQ] = frame_q[POS_SEQ] + 1'b1;
    end
    add_byte(last);
  endtask

  initial begin
    int unsigned      pick;
    frame_kind_e      kind;
    cycles     = 0;
    burst_left = 0;
    words_sent = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // dropped bytes, end with no frame open
    send_word(REQ_BYTE, 8'h00);
    send_word(REQ_BYTE, 8'hFF);
    send_word(REQ_END, 8'hFF);
    // poll with extreme address, buz with extreme fields, closed by a new start
    frame_q = {START_BYTE, 8'hFF, 8'h07, 8'h00, 8'h00, POLL_CODE};
    close_sum();
    send_queue();
    frame_q = {START_BYTE, 8'h00, 8'h0C, 8'h00, 8'hFF, BUZ_CODE,
               8'h01, 8'h02, 8'h80, 8'h7F, 8'hFF};
    close_sum();
    send_queue();
    send_word(REQ_BYTE, START_BYTE);
    send_word(REQ_END, 8'h00);

    while (words_sent < RAND_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 82) begin
        pick = $urandom_range(0, 99);
        if (pick < 30) kind = FR_POLL;
        else if (pick < 60) kind = FR_BUZ;
        else if (pick < 70) kind = FR_LEN_BAD;
        else if (pick < 80) kind = FR_SUM_BAD;
        else if (pick < 90) kind = FR_UNKNOWN;
        else kind = FR_TRUNC;
        build_frame(kind);
        send_queue();
        if ($urandom_range(0, 2) == 0) begin
          send_word(REQ_END, ByteW'($urandom));
          if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) send_word(REQ_BYTE, body_byte());
            send_word(REQ_END, ByteW'($urandom));
          end
        end
      end else begin
        // raw noise, may split or extend an open frame
        repeat ($urandom_range(1, 8))
          send_word(req_e'($urandom_range(0, 1)), ByteW'($urandom));
      end
    end
    send_word(REQ_END, ByteW'($urandom));

    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d words with bursty input and a stalling receiver, %0d verdicts checked",
             words_sent, sb.verdicts_checked);
    $display("verdicts: poll %0d buz %0d short %0d len %0d sum %0d unknown %0d",
             sb.status_hits[ST_POLL], sb.status_hits[ST_BUZ], sb.status_hits[ST_SHORT],
             sb.status_hits[ST_LEN_BAD], sb.status_hits[ST_SUM_BAD],
             sb.status_hits[ST_UNKNOWN]);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[command_frame_parser_core] OK");
    end else begin
      $display("[command_frame_parser_core] ERROR");
    end
    $finish;
  end

endmodule
